FILE: rtl/core/clw53_pkg.sv
// Shared widths, register indexes and reset values of the column lifting core.
`default_nettype none

package clw53_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int LIFT_W         = SAMPLE_W + 1;
  localparam int ROW_W          = 10;
  localparam int COL_W          = 10;
  localparam int WIDTH_REG_W    = 11;
  localparam int HH_REG_W       = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 11;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_INVERSE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_HALF = 2'd2;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RST = 11'd1024;
  localparam logic [HH_REG_W-1:0]    HH_RST    = 10'd512;

endpackage

`default_nettype wire

FILE: rtl/core/clw53_stream_if.sv
// Valid/ready stream interfaces for the sample input and the coefficient output.
`default_nettype none

interface clw53_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [clw53_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, mode, sample, input ready);
  modport sink   (input valid, mode, sample, output ready);
endinterface

interface clw53_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [clw53_pkg::SAMPLE_W-1:0] coefficient;
  logic [clw53_pkg::ROW_W-1:0]           out_row;
  logic [clw53_pkg::COL_W-1:0]           out_col;
  logic                                 end_of_frame;

  modport source (output valid, coefficient, out_row, out_col, end_of_frame, input ready);
  modport sink   (input valid, coefficient, out_row, out_col, end_of_frame, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/clw53_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module clw53_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/column_lifting_wavelet_53_core.sv
// Top level of the 5/3 column lifting core on a raster sample stream.
//
// The core lifts each column of a W x H frame (H = 2 * height_half) with the 5/3 lifting
// steps, forward or inverse as the inverse register selects, while samples arrive in raster
// order. Rows 0 and H-1 pass unchanged. Each coefficient leaves two rows after its sample,
// so once the last sample is in, drain items (mode = 1) flush rows H-2 and H-1, one
// coefficient per drain item; drain items before the frame is complete, and samples after
// it is complete, are taken and dropped. Rate: one item per clock cycle, sustained for as
// long as the output side takes its transfers. Every item does exactly one read and at most
// one write of a single line memory of MAX_WIDTH words, each word holding the two latest
// input samples and the latest lifted value of one column; that one memory port pair is
// what sets the rate. The memory read of an item is issued at its transfer, the lifting
// arithmetic runs in the following cycle and its result enters the output queue at the
// next edge, from where it is offered at once. When two items in a row touch the same
// column (a frame one column wide) the second one takes the just-computed word from a
// bypass register instead of the memory. The line memory needs no clearing after reset;
// its words are all written by the first two rows of a frame before they are used.
// Registers take effect at once and should be written only while the core is idle.
`default_nettype none

module column_lifting_wavelet_53_core #(
  parameter int MAX_WIDTH  = clw53_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = clw53_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [clw53_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [clw53_pkg::CFG_DATA_W-1:0] cfg_data_i,
  clw53_in_if.sink                              in_if,
  clw53_out_if.source                           out_if
);

  localparam int SW     = clw53_pkg::SAMPLE_W;
  localparam int LW     = clw53_pkg::LIFT_W;
  localparam int EW     = SW + 3;
  localparam int MW     = 2 * SW + LW;
  localparam int ROW_W  = clw53_pkg::ROW_W;
  localparam int COL_W  = clw53_pkg::COL_W;
  localparam int WREG_W = clw53_pkg::WIDTH_REG_W;
  localparam int HREG_W = clw53_pkg::HH_REG_W;
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  // Comparison widths: wide enough for the register value and for the largest frame size.
  localparam int WK     = ($clog2(MAX_WIDTH + 1) > WREG_W) ? $clog2(MAX_WIDTH + 1) : WREG_W;
  localparam int HK     = (RW + 1 > HREG_W + 1) ? RW + 1 : HREG_W + 1;
  localparam int HALF_MAX = MAX_HEIGHT / 2;

  localparam logic signed [EW-1:0] SAT_HI = EW'((1 << (SW - 1)) - 1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  // Where a coefficient comes from.
  typedef enum logic [2:0] {
    SRC_LIFT,
    SRC_OLDER,
    SRC_NEWER,
    SRC_ADD_Q,
    SRC_SUB_Q
  } src_e;

  // How the new lifted value is formed from the newer sample and the halved sum.
  typedef enum logic [1:0] {
    Y_NEWER,
    Y_SUB,
    Y_ADD
  } yop_e;

  // Control and operands of one item between the memory read and the arithmetic.
  typedef struct packed {
    logic                 emit;
    logic                 we;
    logic                 lift_we;
    src_e                 src;
    yop_e                 yop;
    logic                 q_newer;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic                 eof;
    logic [AW-1:0]        addr;
    logic signed [SW-1:0] x;
  } stage_t;

  typedef struct packed {
    logic [SW-1:0]    coef;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             eof;
  } result_t;

  // Configuration registers.
  logic              inverse_q;
  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
      width_q   <= clw53_pkg::WIDTH_RST;
      hh_q      <= clw53_pkg::HH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clw53_pkg::REG_INVERSE:     inverse_q <= cfg_data_i[0];
        clw53_pkg::REG_WIDTH:       width_q   <= cfg_data_i[WREG_W-1:0];
        clw53_pkg::REG_HEIGHT_HALF: hh_q      <= cfg_data_i[HREG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register values clamped to their legal range; zero acts as one.
  logic [WK-1:0] width_ext, w_eff;
  logic [HK-1:0] hh_ext, hh_eff, h_eff;

  always_comb begin
    width_ext = WK'(width_q);
    if (width_ext == '0) begin
      w_eff = WK'(1);
    end else if (width_ext > WK'(MAX_WIDTH)) begin
      w_eff = WK'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    hh_ext = HK'(hh_q);
    if (hh_ext == '0) begin
      hh_eff = HK'(1);
    end else if (hh_ext > HK'(HALF_MAX)) begin
      hh_eff = HK'(HALF_MAX);
    end else begin
      hh_eff = hh_ext;
    end
    h_eff = {hh_eff[HK-2:0], 1'b0};
  end

  // Frame position counters.
  logic [AW-1:0] icol_q, icol_d, ocol_q, ocol_d;
  logic [RW-1:0] irow_q, irow_d, orow_q, orow_d;
  logic          loaded_q, loaded_d;

  logic          in_ready, in_fire, samp_go, drain_go;
  logic [WK-1:0] icol_p1, ocol_p1;
  logic [HK-1:0] irow_x, orow_x, irow_p1, orow_p1;
  logic          last_row, row_end;

  assign in_fire  = in_if.valid && in_ready;
  assign samp_go  = in_fire && !in_if.mode && !loaded_q;
  assign drain_go = in_fire && in_if.mode && loaded_q;

  assign icol_p1  = WK'(icol_q) + WK'(1);
  assign ocol_p1  = WK'(ocol_q) + WK'(1);
  assign irow_x   = HK'(irow_q);
  assign orow_x   = HK'(orow_q);
  assign irow_p1  = irow_x + HK'(1);
  assign orow_p1  = orow_x + HK'(1);
  assign last_row = orow_p1 >= h_eff;
  assign row_end  = ocol_p1 >= w_eff;

  always_comb begin
    icol_d   = icol_q;
    irow_d   = irow_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    loaded_d = loaded_q;
    if (samp_go) begin
      if (icol_p1 >= w_eff) begin
        icol_d = '0;
        if (irow_p1 >= h_eff) begin
          loaded_d = 1'b1;
          orow_d   = (irow_q == '0) ? '0 : irow_q - RW'(1);
          ocol_d   = '0;
        end else begin
          irow_d = irow_q + RW'(1);
        end
      end else begin
        icol_d = icol_q + AW'(1);
      end
    end else if (drain_go) begin
      if (row_end) begin
        ocol_d = '0;
        if (last_row) begin
          loaded_d = 1'b0;
          irow_d   = '0;
          icol_d   = '0;
          orow_d   = '0;
        end else begin
          orow_d = orow_q + RW'(1);
        end
      end else begin
        ocol_d = ocol_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q   <= '0;
      irow_q   <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
      loaded_q <= 1'b0;
    end else begin
      icol_q   <= icol_d;
      irow_q   <= irow_d;
      ocol_q   <= ocol_d;
      orow_q   <= orow_d;
      loaded_q <= loaded_d;
    end
  end

  // Decode of the item at its transfer: everything that depends only on position and
  // registers is settled here, the data path in the next cycle only follows it.
  stage_t        s0;
  logic [AW-1:0] rd_addr;

  assign rd_addr = loaded_q ? ocol_q : icol_q;

  always_comb begin
    s0         = '0;
    s0.src     = SRC_LIFT;
    s0.yop     = Y_NEWER;
    s0.addr    = rd_addr;
    s0.x       = in_if.sample;
    if (!in_if.mode) begin
      s0.we  = !loaded_q;
      s0.row = ROW_W'(irow_x - HK'(2));
      s0.col = COL_W'(icol_q);
      if (!inverse_q) begin
        if (irow_q[0]) begin
          // Odd row: predict the row above, update the row two above.
          s0.yop     = (irow_x == HK'(1)) ? Y_NEWER : Y_SUB;
          s0.lift_we = 1'b1;
          s0.emit    = irow_x >= HK'(3);
          s0.src     = SRC_ADD_Q;
        end else begin
          s0.emit = irow_x >= HK'(2);
          s0.src  = SRC_LIFT;
        end
      end else begin
        if (!irow_q[0]) begin
          s0.yop     = Y_ADD;
          s0.lift_we = irow_x >= HK'(2);
          s0.emit    = irow_x >= HK'(2);
          s0.src     = (irow_x == HK'(2)) ? SRC_OLDER : SRC_SUB_Q;
        end else begin
          s0.emit = irow_x >= HK'(3);
          s0.src  = SRC_LIFT;
        end
      end
      s0.emit    = s0.emit && !loaded_q;
      s0.lift_we = s0.lift_we && !loaded_q;
    end else begin
      // Drain of the two rows still held in the line memory.
      s0.emit    = loaded_q;
      s0.row     = ROW_W'(orow_q);
      s0.col     = COL_W'(ocol_q);
      s0.eof     = last_row && row_end;
      s0.q_newer = 1'b1;
      if (last_row) begin
        s0.src = SRC_NEWER;
      end else if (!inverse_q) begin
        s0.src = SRC_LIFT;
      end else if (orow_q == '0) begin
        s0.src = SRC_OLDER;
      end else begin
        s0.src = SRC_SUB_Q;
      end
    end
  end

  // Second stage: memory data is here, compute and write back.
  stage_t        s1_q;
  logic          s1_valid_q;
  logic [MW-1:0] ram_rdata, word, wr_word, fwd_word_q;
  logic          fwd_hit_q, ram_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      fwd_hit_q  <= ram_we && in_fire && (rd_addr == s1_q.addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s0;
    end
    fwd_word_q <= wr_word;
  end

  assign ram_we = s1_valid_q && s1_q.we;

  clw53_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (wr_word),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // A write of the previous cycle to the same column is not yet in the read data.
  assign word = fwd_hit_q ? fwd_word_q : ram_rdata;

  logic signed [SW-1:0] older, newer, half;
  logic signed [LW-1:0] lifted, y;
  logic signed [SW:0]   sum_ox;
  logic signed [EW-1:0] qin, tsum, older_e, q_e, res;
  logic signed [SW:0]   q;
  logic [SW-1:0]        coef;

  always_comb begin
    older  = word[SW-1:0];
    newer  = word[2*SW-1:SW];
    lifted = word[MW-1:2*SW];
    sum_ox = {older[SW-1], older} + {s1_q.x[SW-1], s1_q.x};
    half   = sum_ox[SW:1];
    unique case (s1_q.yop)
      Y_SUB:   y = {newer[SW-1], newer} - {half[SW-1], half};
      Y_ADD:   y = {newer[SW-1], newer} + {half[SW-1], half};
      default: y = {newer[SW-1], newer};
    endcase
    qin     = s1_q.q_newer ? {{3{newer[SW-1]}}, newer} : {{2{y[LW-1]}}, y};
    tsum    = {{2{lifted[LW-1]}}, lifted} + qin + EW'(2);
    q       = tsum[EW-1:2];
    older_e = {{3{older[SW-1]}}, older};
    q_e     = {{2{q[SW]}}, q};
    unique case (s1_q.src)
      SRC_OLDER: res = older_e;
      SRC_NEWER: res = {{3{newer[SW-1]}}, newer};
      SRC_ADD_Q: res = older_e + q_e;
      SRC_SUB_Q: res = older_e - q_e;
      default:   res = {{2{lifted[LW-1]}}, lifted};
    endcase
    if (res > SAT_HI) begin
      coef = SAT_HI[SW-1:0];
    end else if (res < SAT_LO) begin
      coef = SAT_LO[SW-1:0];
    end else begin
      coef = res[SW-1:0];
    end
    wr_word = {(s1_q.lift_we ? y : lifted), s1_q.x, newer};
  end

  // Two-entry output queue; its occupancy plus the item in flight, or a pop, sets ready.
  result_t     qmem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  logic [2:0]  pending;

  assign push    = s1_valid_q && s1_q.emit;
  assign pop     = out_if.valid && out_if.ready;
  assign pending = {1'b0, cnt_q} + {2'b00, push};
  assign in_ready = (pending <= 3'd1) || pop;
  assign in_if.ready = in_ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      qmem_q[wr_ptr_q] <= '{coef: coef, row: s1_q.row, col: s1_q.col, eof: s1_q.eof};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign out_if.valid        = cnt_q != 2'd0;
  assign out_if.coefficient  = qmem_q[rd_ptr_q].coef;
  assign out_if.out_row      = qmem_q[rd_ptr_q].row;
  assign out_if.out_col      = qmem_q[rd_ptr_q].col;
  assign out_if.end_of_frame = qmem_q[rd_ptr_q].eof;

endmodule

`default_nettype wire

FILE: rtl/core/clw53_checker.sv
// Port-level assertions for the column lifting core and their bind to the top level.
`default_nettype none

module clw53_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [clw53_pkg::SAMPLE_W-1:0] coefficient_i,
  input wire logic [clw53_pkg::ROW_W-1:0]    out_row_i,
  input wire logic [clw53_pkg::COL_W-1:0]    out_col_i,
  input wire logic                          end_of_frame_i
);

  localparam int COL_W = clw53_pkg::COL_W;

  logic             in_xfer, out_xfer;
  logic [31:0]      credit_q;
  logic [COL_W-1:0] last_col_q;
  logic             seen_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Items taken minus coefficients delivered; a result always has an item behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q   <= '0;
      last_col_q <= '0;
      seen_q     <= 1'b0;
    end else begin
      if (in_xfer && !out_xfer && credit_q != '1) begin
        credit_q <= credit_q + 32'd1;
      end else if (out_xfer && !in_xfer && credit_q != '0) begin
        credit_q <= credit_q - 32'd1;
      end
      if (out_xfer) begin
        last_col_q <= out_col_i;
        seen_q     <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("coefficient offer withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(coefficient_i) && $stable(out_row_i) &&
                                   $stable(out_col_i) && $stable(end_of_frame_i))
    else $error("stalled coefficient changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> credit_q != '0)
    else $error("coefficient offered without an item taken for it");

  a_col_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && seen_q |-> (out_col_i == COL_W'(last_col_q + COL_W'(1))) ||
                           (out_col_i == '0))
    else $error("coefficient column skipped or repeated");

endmodule

bind column_lifting_wavelet_53_core clw53_checker u_clw53_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_if.valid),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .coefficient_i  (out_if.coefficient),
  .out_row_i      (out_if.out_row),
  .out_col_i      (out_if.out_col),
  .end_of_frame_i (out_if.end_of_frame)
);

`default_nettype wire

FILE: bench/column_lifting_wavelet_53_core_test.sv
// Self-checking testbench for the 5/3 column lifting core: random and directed frames.
`timescale 1ns / 1ps

module column_lifting_wavelet_53_core_test;

  // Item kinds on the input channel.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  localparam logic signed [clw53_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [clw53_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Which registers a call of program_regs writes.
  localparam logic [2:0] SET_INVERSE = 3'b001;
  localparam logic [2:0] SET_WIDTH   = 3'b010;
  localparam logic [2:0] SET_HEIGHT  = 3'b100;
  localparam logic [2:0] SET_ALL     = 3'b111;

  // Allow a good margin before touching registers or ending the run.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 800;
  localparam int REPORT_LIMIT  = 10;
  // Transfer counts at which the idling profile changes.
  localparam int PHASE_ONE_END = 640;
  localparam int PHASE_TWO_END = 1280;

  typedef enum int {
    PAT_RANDOM,
    PAT_CHECKER,
    PAT_CHECKER_INV,
    PAT_FLAT_MAX,
    PAT_FLAT_MIN
  } pattern_e;

  typedef struct packed {
    logic signed [clw53_pkg::SAMPLE_W-1:0] coefficient;
    logic [clw53_pkg::ROW_W-1:0]           row;
    logic [clw53_pkg::COL_W-1:0]           col;
    logic                                  eof;
  } coef_t;

  // Scoreboard: keeps its own copy of the line stores, the stream position and
  // the registers, predicts the coefficients caused by the accepted items and
  // compares the coefficients that leave the core in order.
  class lift_scoreboard;
    logic                                  inverse_q;
    logic [clw53_pkg::WIDTH_REG_W-1:0]     width_q;
    logic [clw53_pkg::HH_REG_W-1:0]        hh_q;
    logic signed [clw53_pkg::SAMPLE_W-1:0] older_line  [clw53_pkg::MAX_WIDTH_DEF];
    logic signed [clw53_pkg::SAMPLE_W-1:0] newer_line  [clw53_pkg::MAX_WIDTH_DEF];
    logic signed [clw53_pkg::LIFT_W-1:0]   lifted_line [clw53_pkg::MAX_WIDTH_DEF];
    int    in_row, in_col, out_row, out_col;
    bit    loaded;
    coef_t awaited_coefs [$];
    int    faults, compared, taken_items, ignored_items, frames_done;

    function new();
      inverse_q = 1'b0;
      width_q   = clw53_pkg::WIDTH_RST;
      hh_q      = clw53_pkg::HH_RST;
      foreach (older_line[i]) begin
        older_line[i]  = '0;
        newer_line[i]  = '0;
        lifted_line[i] = '0;
      end
    endfunction

    function void set_register(logic [clw53_pkg::CFG_IDX_W-1:0] idx,
                               logic [clw53_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        clw53_pkg::REG_INVERSE:     inverse_q = data[0];
        clw53_pkg::REG_WIDTH:       width_q = data[clw53_pkg::WIDTH_REG_W-1:0];
        clw53_pkg::REG_HEIGHT_HALF: hh_q = data[clw53_pkg::HH_REG_W-1:0];
        default: ;
      endcase
    endfunction

    // Effective frame size: out-of-range register values are clamped.
    function int frame_cols();
      int w;
      w = int'(width_q);
      if (w < 1) w = 1;
      if (w > clw53_pkg::MAX_WIDTH_DEF) w = clw53_pkg::MAX_WIDTH_DEF;
      return w;
    endfunction

    function int frame_rows();
      int h;
      h = int'(hh_q);
      if (h < 1) h = 1;
      if (h > clw53_pkg::MAX_HEIGHT_DEF / 2) h = clw53_pkg::MAX_HEIGHT_DEF / 2;
      return 2 * h;
    endfunction

    function void push_coef(int v, int row, int col, bit eof);
      coef_t e;
      if (v > 32767) e.coefficient = SAMPLE_MAX;
      else if (v < -32768) e.coefficient = SAMPLE_MIN;
      else e.coefficient = clw53_pkg::SAMPLE_W'(v);
      e.row = clw53_pkg::ROW_W'(row);
      e.col = clw53_pkg::COL_W'(col);
      e.eof = eof;
      awaited_coefs.push_back(e);
    endfunction

    // Predicts the effect of one accepted item. Arithmetic shifts of signed
    // ints give the floor divisions of the lifting steps.
    function void note_item(logic mode, logic signed [clw53_pkg::SAMPLE_W-1:0] sample);
      int w, h, r, c, x, older, newer, lifted, y, v;
      bit last_row, row_end;
      w = frame_cols();
      h = frame_rows();
      if (mode == MODE_SAMPLE) begin
        if (loaded) begin
          ignored_items++;
          return;
        end
        taken_items++;
        r = in_row;
        c = (in_col < clw53_pkg::MAX_WIDTH_DEF) ? in_col : clw53_pkg::MAX_WIDTH_DEF - 1;
        x = sample;
        older = older_line[c];
        newer = newer_line[c];
        lifted = lifted_line[c];
        if (!inverse_q) begin
          if (r[0]) begin
            y = (r == 1) ? newer : newer - ((older + x) >>> 1);
            if (r >= 3) push_coef(older + ((lifted + y + 2) >>> 2), r - 2, c, 1'b0);
            lifted_line[c] = clw53_pkg::LIFT_W'(y);
          end else if (r >= 2) begin
            push_coef(lifted, r - 2, c, 1'b0);
          end
        end else begin
          if (!r[0] && r >= 2) begin
            y = newer + ((older + x) >>> 1);
            v = (r == 2) ? older : older - ((lifted + y + 2) >>> 2);
            push_coef(v, r - 2, c, 1'b0);
            lifted_line[c] = clw53_pkg::LIFT_W'(y);
          end else if (r[0] && r >= 3) begin
            push_coef(lifted, r - 2, c, 1'b0);
          end
        end
        older_line[c] = clw53_pkg::SAMPLE_W'(newer);
        newer_line[c] = clw53_pkg::SAMPLE_W'(x);
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          if (r + 1 >= h) begin
            loaded = 1'b1;
            out_row = (r >= 1) ? r - 1 : 0;
            out_col = 0;
          end else begin
            in_row++;
          end
        end
        return;
      end
      if (!loaded) begin
        ignored_items++;
        return;
      end
      taken_items++;
      c = (out_col < clw53_pkg::MAX_WIDTH_DEF) ? out_col : clw53_pkg::MAX_WIDTH_DEF - 1;
      older = older_line[c];
      newer = newer_line[c];
      lifted = lifted_line[c];
      last_row = (out_row + 1 >= h);
      row_end = (out_col + 1 >= w);
      if (last_row) v = newer;
      else if (!inverse_q) v = lifted;
      else if (out_row == 0) v = older;
      else v = older - ((lifted + newer + 2) >>> 2);
      push_coef(v, out_row, c, last_row && row_end);
      if (row_end) begin
        out_col = 0;
        if (last_row) begin
          loaded = 1'b0;
          in_row = 0;
          in_col = 0;
          out_row = 0;
          frames_done++;
        end else begin
          out_row++;
        end
      end else begin
        out_col++;
      end
    endfunction

    function void check_coefficient(coef_t got);
      coef_t want;
      if (awaited_coefs.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("Unexpected coefficient %0d at row %0d col %0d eof %0b",
                   $signed(got.coefficient), got.row, got.col, got.eof);
        return;
      end
      want = awaited_coefs.pop_front();
      compared++;
      if (got.coefficient !== want.coefficient || got.row !== want.row ||
          got.col !== want.col || got.eof !== want.eof) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display({"Mismatch: expected %0d row %0d col %0d eof %0b, ",
                    "got %0d row %0d col %0d eof %0b"},
                   $signed(want.coefficient), want.row, want.col, want.eof,
                   $signed(got.coefficient), got.row, got.col, got.eof);
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [clw53_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [clw53_pkg::CFG_DATA_W-1:0] cfg_data_i;

  clw53_in_if  in_ch ();
  clw53_out_if out_ch ();

  lift_scoreboard sb = new();

  // Idling profile: the sender idles lightly and the receiver heavily first,
  // then the other way round, and finally both run flat out.
  int sender_idle_pct   = 29;
  int receiver_idle_pct = 72;
  int transfers         = 0;

  column_lifting_wavelet_53_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offers one item, with a random number of idle cycles ahead of it, and
  // returns at the edge where the transfer happens. Valid is left high so a
  // following item can go out back to back.
  task automatic send_item(input logic mode,
                           input logic signed [clw53_pkg::SAMPLE_W-1:0] sample);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.sample <= sample;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_item(mode, sample);
    transfers++;
    if (transfers < PHASE_ONE_END) begin
      sender_idle_pct   = 29;
      receiver_idle_pct = 72;
    end else if (transfers < PHASE_TWO_END) begin
      sender_idle_pct   = 72;
      receiver_idle_pct = 29;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
  endtask

  // Stops offering items, waits for every predicted coefficient and then lets
  // the pipeline run empty, since dropped items leave no coefficient to wait on.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.awaited_coefs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [clw53_pkg::CFG_IDX_W-1:0] idx,
                           input logic [clw53_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  // Registers are only written while the core is idle, so settle first. The
  // write enable stays high across consecutive writes and drops once at the end.
  task automatic program_regs(input logic [2:0] mask, input logic inv,
                              input logic [clw53_pkg::WIDTH_REG_W-1:0] w,
                              input logic [clw53_pkg::HH_REG_W-1:0] hh);
    settle();
    if (mask & SET_INVERSE)
      write_reg(clw53_pkg::REG_INVERSE, clw53_pkg::CFG_DATA_W'(inv));
    if (mask & SET_WIDTH)
      write_reg(clw53_pkg::REG_WIDTH, clw53_pkg::CFG_DATA_W'(w));
    if (mask & SET_HEIGHT)
      write_reg(clw53_pkg::REG_HEIGHT_HALF, clw53_pkg::CFG_DATA_W'(hh));
    cfg_we_i <= 1'b0;
  endtask

  // Streams one frame and drains it, steered by the predicted stream position.
  // A noisy frame mixes in drain items while loading and samples while
  // draining; the core must drop both. A retuned frame changes registers once
  // at a row boundary from row 3 on: the mode flips, the height may change and
  // the width may only shrink, so no column is read before this frame wrote it.
  task automatic run_frame(input pattern_e pattern, input bit noisy, input bit retune);
    bit                                    retuned;
    logic signed [clw53_pkg::SAMPLE_W-1:0] s;
    int                                    pick;
    logic [2:0]                            mask;
    retuned = 1'b0;
    while (!sb.loaded) begin
      if (noisy && $urandom_range(15) == 0) send_item(MODE_DRAIN, 16'($urandom));
      if (retune && !retuned && sb.in_row >= 3 && sb.in_col == 0 &&
          $urandom_range(3) == 0) begin
        retuned = 1'b1;
        mask = SET_INVERSE | 3'($urandom_range(7)) & (SET_WIDTH | SET_HEIGHT);
        if (sb.frame_cols() < 2) mask = mask & ~SET_WIDTH;
        program_regs(mask, ~sb.inverse_q,
                     clw53_pkg::WIDTH_REG_W'($urandom_range(1, sb.frame_cols() - 1)),
                     clw53_pkg::HH_REG_W'($urandom_range(1, 8)));
      end
      case (pattern)
        PAT_CHECKER:     s = ((sb.in_row ^ sb.in_col) & 1) ? SAMPLE_MIN : SAMPLE_MAX;
        PAT_CHECKER_INV: s = ((sb.in_row ^ sb.in_col) & 1) ? SAMPLE_MAX : SAMPLE_MIN;
        PAT_FLAT_MAX:    s = SAMPLE_MAX;
        PAT_FLAT_MIN:    s = SAMPLE_MIN;
        default: begin
          pick = $urandom_range(9);
          if (pick == 0) s = SAMPLE_MAX;
          else if (pick == 1) s = SAMPLE_MIN;
          else if (pick < 4) s = 16'($urandom_range(16) - 8);
          else s = 16'($urandom);
        end
      endcase
      send_item(MODE_SAMPLE, s);
    end
    while (sb.loaded) begin
      if (noisy && $urandom_range(7) == 0) send_item(MODE_SAMPLE, 16'($urandom));
      send_item(MODE_DRAIN, 16'($urandom));
    end
    if (noisy) send_item(MODE_DRAIN, 16'($urandom));
  endtask

  // Output side: takes a coefficient at every edge where valid and ready are
  // both high and hands it to the scoreboard, then decides the next ready.
  initial begin
    coef_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.coefficient = out_ch.coefficient;
        got.row         = out_ch.out_row;
        got.col         = out_ch.out_col;
        got.eof         = out_ch.end_of_frame;
        sb.check_coefficient(got);
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Stimulus: a few directed frames, a random part, then the tallest frame.
  initial begin
    int                                start_taken;
    int                                pick;
    logic [2:0]                        mask;
    pattern_e                          pattern;
    logic [clw53_pkg::WIDTH_REG_W-1:0] w;
    logic [clw53_pkg::HH_REG_W-1:0]    hh;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= clw53_pkg::REG_INVERSE;
    cfg_data_i   <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.mode   <= MODE_SAMPLE;
    in_ch.sample <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero registers act as one: a frame of one column and two rows. A drain
    // before the frame is complete, a sample after it and a drain after the
    // frame has left must all be dropped.
    program_regs(SET_ALL, 1'b0, '0, '0);
    send_item(MODE_DRAIN, 16'sh5a5a);
    send_item(MODE_SAMPLE, SAMPLE_MAX);
    send_item(MODE_SAMPLE, SAMPLE_MIN);
    send_item(MODE_SAMPLE, '0);
    send_item(MODE_DRAIN, 16'sh0000);
    send_item(MODE_DRAIN, 16'shffff);
    send_item(MODE_DRAIN, 16'sha5a5);

    // Extreme samples that push both lifting directions into saturation.
    program_regs(SET_ALL, 1'b1, 11'd2, 10'd2);
    run_frame(PAT_FLAT_MAX, 1'b0, 1'b0);
    program_regs(SET_ALL, 1'b0, 11'd2, 10'd2);
    run_frame(PAT_CHECKER, 1'b0, 1'b0);

    // Random frames, mostly small, with random content, some noise and the
    // occasional register change in the middle of a frame.
    start_taken = sb.taken_items;
    while (sb.taken_items - start_taken < RANDOM_ITEMS) begin
      mask = ($urandom_range(3) == 0) ? 3'($urandom_range(1, 7)) : SET_ALL;
      pick = $urandom_range(19);
      if (pick == 0) w = '0;
      else if (pick == 1) w = clw53_pkg::WIDTH_REG_W'($urandom_range(13, 24));
      else w = clw53_pkg::WIDTH_REG_W'($urandom_range(1, 12));
      pick = $urandom_range(19);
      if (pick == 0) hh = '0;
      else if (pick == 1) hh = clw53_pkg::HH_REG_W'($urandom_range(7, 10));
      else hh = clw53_pkg::HH_REG_W'($urandom_range(1, 6));
      program_regs(mask, 1'($urandom), w, hh);
      pick = $urandom_range(9);
      case (pick)
        0: pattern = PAT_CHECKER;
        1: pattern = PAT_CHECKER_INV;
        2: pattern = PAT_FLAT_MAX;
        3: pattern = PAT_FLAT_MIN;
        default: pattern = PAT_RANDOM;
      endcase
      run_frame(pattern, $urandom_range(2) == 0, $urandom_range(5) == 0);
    end

    // Tallest frame: an oversized height register gives 1024 rows of one column.
    program_regs(SET_ALL, 1'b1, '0, 10'd1023);
    run_frame(PAT_RANDOM, 1'b0, 1'b0);

    settle();
    $display("Covered %0d frames: %0d items used, %0d dropped, %0d coefficients compared.",
             sb.frames_done, sb.taken_items, sb.ignored_items, sb.compared);
    $display("Forward and inverse lifting, widths 1 to 24, heights 2 to 1024, %0d faults.",
             sb.faults);
    if (sb.faults == 0 && sb.awaited_coefs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timeout with %0d coefficients still awaited.", sb.awaited_coefs.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
